@@ rtl/core/bamaux_pkg.sv @@
// package for the auxiliary block parser: phase and role codes, type characters, size tables
package bamaux_pkg;

  // parse phase of the current entry
  typedef enum logic [2:0] {
    PH_TAG0   = 3'd0,
    PH_TAG1   = 3'd1,
    PH_TYPE   = 3'd2,
    PH_SUB    = 3'd3,
    PH_COUNT  = 3'd4,
    PH_VALUE  = 3'd5,
    PH_STRING = 3'd6
  } phase_t;

  // role reported for each byte
  typedef enum logic [2:0] {
    ROLE_TAG     = 3'd0,
    ROLE_TYPE    = 3'd1,
    ROLE_SUBTYPE = 3'd2,
    ROLE_COUNT   = 3'd3,
    ROLE_VALUE   = 3'd4,
    ROLE_STR_END = 3'd5
  } role_t;

  // type characters
  localparam logic [7:0] CH_A_UP = 8'h41;  // 'A'
  localparam logic [7:0] CH_C_LO = 8'h63;  // 'c'
  localparam logic [7:0] CH_C_UP = 8'h43;  // 'C'
  localparam logic [7:0] CH_S_LO = 8'h73;  // 's'
  localparam logic [7:0] CH_S_UP = 8'h53;  // 'S'
  localparam logic [7:0] CH_I_LO = 8'h69;  // 'i'
  localparam logic [7:0] CH_I_UP = 8'h49;  // 'I'
  localparam logic [7:0] CH_F_LO = 8'h66;  // 'f'
  localparam logic [7:0] CH_D_LO = 8'h64;  // 'd'
  localparam logic [7:0] CH_Z_UP = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_H_UP = 8'h48;  // 'H'
  localparam logic [7:0] CH_B_UP = 8'h42;  // 'B'

  // one result of the parser
  typedef struct packed {
    logic [7:0]  data_byte;
    role_t       role;
    logic [15:0] entry_tag;
    logic [7:0]  type_code;
    logic [7:0]  sub_type;
    logic        entry_done;
    logic        unknown_type;
    logic        truncated;
  } result_t;

  // byte size of a scalar value, zero for anything else
  function automatic logic [3:0] scalar_size(input logic [7:0] t);
    logic [3:0] sz;
    unique case (t)
      CH_A_UP, CH_C_LO, CH_C_UP:          sz = 4'd1;
      CH_S_LO, CH_S_UP:                   sz = 4'd2;
      CH_I_LO, CH_I_UP, CH_F_LO:          sz = 4'd4;
      CH_D_LO:                            sz = 4'd8;
      default:                            sz = 4'd0;
    endcase
    return sz;
  endfunction

  // byte size of an array element, zero for a bad subtype
  function automatic logic [3:0] element_size(input logic [7:0] t);
    logic [3:0] sz;
    unique case (t)
      CH_C_LO, CH_C_UP:                   sz = 4'd1;
      CH_S_LO, CH_S_UP:                   sz = 4'd2;
      CH_I_LO, CH_I_UP, CH_F_LO:          sz = 4'd4;
      default:                            sz = 4'd0;
    endcase
    return sz;
  endfunction

endpackage

@@ rtl/core/bamaux_ifs.sv @@
// request channel interfaces for the auxiliary block parser

// input byte channel
interface bamaux_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] aux_byte;
  logic       block_last;

  modport source (output valid, output aux_byte, output block_last, input ready);
  modport sink   (input valid, input aux_byte, input block_last, output ready);
endinterface

// result channel
interface bamaux_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [2:0]  role;
  logic [15:0] entry_tag;
  logic [7:0]  type_code;
  logic [7:0]  sub_type;
  logic        entry_done;
  logic        unknown_type;
  logic        truncated;

  modport source (output valid, output data_byte, output role, output entry_tag,
                  output type_code, output sub_type, output entry_done,
                  output unknown_type, output truncated, input ready);
  modport sink   (input valid, input data_byte, input role, input entry_tag,
                  input type_code, input sub_type, input entry_done,
                  input unknown_type, input truncated, output ready);
endinterface

@@ rtl/core/bam_aux_field_parser_top.sv @@
// auxiliary block parser of one alignment record, one byte per request
//
// in_ch carries one byte of the auxiliary block per request, with block_last
// on the final byte. every byte gives exactly one request on out_ch naming
// its role (tag, type, subtype, count, value, string end) together with the
// tag, type and subtype of the entry it belongs to, and entry_done on the
// byte that completes the entry.
// a result is in the output register in the cycle after its byte is taken.
// throughput: one byte per cycle while the receiver takes each result; the
// parse state update is a single pass through the phase logic, the 32-bit
// count decrement being the longest path.
// reset (rst_n low, synchronous) returns the parser to the first tag byte
// and empties the output register. on a byte with block_last the parse state
// returns to the same point, and truncated is raised if the entry was open.
// when the receiver stalls, the result holds in the output register and
// in_ch.ready drops until it is taken; a byte is taken in the same cycle
// that the held result leaves.
module bam_aux_field_parser_top (
  input  logic clk,
  input  logic rst_n,
  bamaux_in_if.sink    in_ch,
  bamaux_out_if.source out_ch
);
  import bamaux_pkg::*;

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic [3:0]  bleft_r, bleft_nxt;
  logic [31:0] elems_r, elems_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  // output register
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic        in_fire;
  logic [7:0]  b;
  logic [3:0]  sz_scalar;
  logic [3:0]  sz_elem;
  logic [3:0]  bleft_dec;
  logic [31:0] elems_dec;
  logic [31:0] elems_or;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.aux_byte;

  assign sz_scalar = scalar_size(b);
  assign sz_elem   = element_size(sub_r);
  assign bleft_dec = bleft_r - 4'd1;
  assign elems_dec = elems_r - 32'd1;
  assign elems_or  = elems_r | ({24'd0, b} << {cnt_r, 3'b000});

  // phase logic for one byte
  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    type_nxt  = type_r;
    sub_nxt   = sub_r;
    bleft_nxt = bleft_r;
    elems_nxt = elems_r;
    cnt_nxt   = cnt_r;
    res_nxt.data_byte    = b;
    res_nxt.role         = ROLE_TAG;
    res_nxt.entry_done   = 1'b0;
    res_nxt.unknown_type = 1'b0;

    unique case (phase_r)
      PH_TAG0: begin
        tag_nxt   = {b, 8'd0};
        type_nxt  = 8'd0;
        sub_nxt   = 8'd0;
        phase_nxt = PH_TAG1;
      end
      PH_TAG1: begin
        tag_nxt   = {tag_r[15:8], b};
        phase_nxt = PH_TYPE;
      end
      PH_TYPE: begin
        res_nxt.role = ROLE_TYPE;
        type_nxt     = b;
        sub_nxt      = 8'd0;
        if (sz_scalar != 4'd0) begin
          bleft_nxt = sz_scalar;
          phase_nxt = PH_VALUE;
        end else if (b == CH_Z_UP || b == CH_H_UP) begin
          phase_nxt = PH_STRING;
        end else if (b == CH_B_UP) begin
          phase_nxt = PH_SUB;
        end else begin
          res_nxt.unknown_type = 1'b1;
          res_nxt.entry_done   = 1'b1;
          phase_nxt            = PH_TAG0;
        end
      end
      PH_SUB: begin
        res_nxt.role = ROLE_SUBTYPE;
        sub_nxt      = b;
        cnt_nxt      = 2'd0;
        elems_nxt    = 32'd0;
        phase_nxt    = PH_COUNT;
      end
      PH_COUNT: begin
        res_nxt.role = ROLE_COUNT;
        elems_nxt    = elems_or;
        if (cnt_r == 2'd3) begin
          cnt_nxt = 2'd0;
          // non-positive count or bad subtype ends the entry here
          if (elems_or == 32'd0 || elems_or[31] || sz_elem == 4'd0) begin
            res_nxt.entry_done = 1'b1;
            phase_nxt          = PH_TAG0;
          end else begin
            bleft_nxt = sz_elem;
            phase_nxt = PH_VALUE;
          end
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      PH_VALUE: begin
        res_nxt.role = ROLE_VALUE;
        bleft_nxt    = bleft_dec;
        if (bleft_dec == 4'd0) begin
          if (type_r == CH_B_UP) begin
            elems_nxt = elems_dec;
            bleft_nxt = sz_elem;
            if (elems_dec == 32'd0 || sz_elem == 4'd0) begin
              res_nxt.entry_done = 1'b1;
              phase_nxt          = PH_TAG0;
            end
          end else begin
            res_nxt.entry_done = 1'b1;
            phase_nxt          = PH_TAG0;
          end
        end
      end
      PH_STRING: begin
        if (b == 8'd0) begin
          res_nxt.role       = ROLE_STR_END;
          res_nxt.entry_done = 1'b1;
          phase_nxt          = PH_TAG0;
        end else begin
          res_nxt.role = ROLE_VALUE;
        end
      end
      default: begin
        // unused phase code: restart as a first tag byte
        tag_nxt   = {b, 8'd0};
        type_nxt  = 8'd0;
        sub_nxt   = 8'd0;
        bleft_nxt = 4'd0;
        elems_nxt = 32'd0;
        cnt_nxt   = 2'd0;
        phase_nxt = PH_TAG1;
      end
    endcase

    res_nxt.entry_tag = tag_nxt;
    res_nxt.type_code = type_nxt;
    res_nxt.sub_type  = sub_nxt;
    res_nxt.truncated = in_ch.block_last && (phase_nxt != PH_TAG0);
  end

  // parse state registers, cleared at the end of each block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG0;
      tag_r   <= 16'd0;
      type_r  <= 8'd0;
      sub_r   <= 8'd0;
      bleft_r <= 4'd0;
      elems_r <= 32'd0;
      cnt_r   <= 2'd0;
    end else if (in_fire) begin
      if (in_ch.block_last) begin
        phase_r <= PH_TAG0;
        tag_r   <= 16'd0;
        type_r  <= 8'd0;
        sub_r   <= 8'd0;
        bleft_r <= 4'd0;
        elems_r <= 32'd0;
        cnt_r   <= 2'd0;
      end else begin
        phase_r <= phase_nxt;
        tag_r   <= tag_nxt;
        type_r  <= type_nxt;
        sub_r   <= sub_nxt;
        bleft_r <= bleft_nxt;
        elems_r <= elems_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_byte    = res_r.data_byte;
  assign out_ch.role         = res_r.role;
  assign out_ch.entry_tag    = res_r.entry_tag;
  assign out_ch.type_code    = res_r.type_code;
  assign out_ch.sub_type     = res_r.sub_type;
  assign out_ch.entry_done   = res_r.entry_done;
  assign out_ch.unknown_type = res_r.unknown_type;
  assign out_ch.truncated    = res_r.truncated;

`ifndef SYNTHESIS
  // end of block always returns the parser to the first tag byte
  a_block_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.block_last |=> phase_r == PH_TAG0 && tag_r == 16'd0)
    else $error("parser not reset after block end");

  // an unknown type closes its entry at the type byte
  a_unknown_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.unknown_type |-> res_r.entry_done && res_r.role == ROLE_TYPE)
    else $error("unknown type without entry end");

  // a zero byte in a string is reported as the terminator
  a_string_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_STRING && in_ch.aux_byte == 8'd0
    |=> out_valid_r && res_r.role == ROLE_STR_END && res_r.entry_done)
    else $error("string terminator not reported");

  // a value phase always has bytes left in the element
  a_value_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_VALUE |-> bleft_r != 4'd0)
    else $error("value phase with empty element");

  // a completed entry is never truncated
  a_trunc_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.truncated |-> !res_r.entry_done)
    else $error("completed entry flagged as truncated");
`endif

endmodule

@@ tb/tb_bam_aux_field_parser_top.sv @@
// testbench for the auxiliary block parser: directed table, random blocks, predicted results
`timescale 1ns / 1ps

module tb_bam_aux_field_parser_top;
  import bamaux_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1125;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_AT     = 400;
  localparam int STALL_CYCLES = 300;
  localparam int MAX_PRINTED  = 30;

  // one byte request, with an optional hand-written expected result
  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         has_lit;
    result_t    lit;
  } aux_req_t;

  logic clk;
  logic rst_n;

  bamaux_in_if  in_ch ();
  bamaux_out_if out_ch ();

  bam_aux_field_parser_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  aux_req_t aux_reqs[$];
  result_t  pending_results[$];
  int       dir_cnt;
  int       acc_idx   = 0;
  int       err_cnt   = 0;
  int       cycle_cnt = 0;

  // parser state as predicted
  phase_t      prs_phase;
  logic [15:0] prs_tag;
  logic [7:0]  prs_type;
  logic [7:0]  prs_sub;
  logic [3:0]  prs_bytes_left;
  logic [31:0] prs_elems_left;
  logic [1:0]  prs_cnt_idx;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // value sizes of scalar types
  function automatic logic [3:0] scalar_len(input logic [7:0] t);
    case (t)
      CH_A_UP, CH_C_LO, CH_C_UP: return 4'd1;
      CH_S_LO, CH_S_UP:          return 4'd2;
      CH_I_LO, CH_I_UP, CH_F_LO: return 4'd4;
      CH_D_LO:                   return 4'd8;
      default:                   return 4'd0;
    endcase
  endfunction

  // element sizes of array subtypes
  function automatic logic [3:0] elem_len(input logic [7:0] t);
    case (t)
      CH_C_LO, CH_C_UP:          return 4'd1;
      CH_S_LO, CH_S_UP:          return 4'd2;
      CH_I_LO, CH_I_UP, CH_F_LO: return 4'd4;
      default:                   return 4'd0;
    endcase
  endfunction

  function automatic void reset_parser();
    prs_phase      = PH_TAG0;
    prs_tag        = '0;
    prs_type       = '0;
    prs_sub        = '0;
    prs_bytes_left = '0;
    prs_elems_left = '0;
    prs_cnt_idx    = '0;
  endfunction

  // predicted result of one byte, advancing the parser state
  function automatic result_t parse_byte(input logic [7:0] b, input logic last);
    result_t    r;
    logic [3:0] sz;
    r = '0;
    r.data_byte = b;
    r.role = ROLE_TAG;
    case (prs_phase)
      PH_TAG0: begin
        prs_tag   = {b, 8'h00};
        prs_type  = '0;
        prs_sub   = '0;
        prs_phase = PH_TAG1;
      end
      PH_TAG1: begin
        prs_tag[7:0] = b;
        prs_phase    = PH_TYPE;
      end
      PH_TYPE: begin
        r.role   = ROLE_TYPE;
        prs_type = b;
        prs_sub  = '0;
        sz = scalar_len(b);
        if (sz != 0) begin
          prs_bytes_left = sz;
          prs_phase      = PH_VALUE;
        end else if (b == CH_Z_UP || b == CH_H_UP) begin
          prs_phase = PH_STRING;
        end else if (b == CH_B_UP) begin
          prs_phase = PH_SUB;
        end else begin
          r.unknown_type = 1'b1;
          r.entry_done   = 1'b1;
          prs_phase      = PH_TAG0;
        end
      end
      PH_SUB: begin
        r.role         = ROLE_SUBTYPE;
        prs_sub        = b;
        prs_cnt_idx    = '0;
        prs_elems_left = '0;
        prs_phase      = PH_COUNT;
      end
      PH_COUNT: begin
        r.role = ROLE_COUNT;
        prs_elems_left = prs_elems_left | (32'(b) << (8 * prs_cnt_idx));
        if (prs_cnt_idx == 2'd3) begin
          prs_cnt_idx = '0;
          sz = elem_len(prs_sub);
          // empty, negative or bad-subtype arrays end on the last count byte
          if (prs_elems_left == 0 || prs_elems_left[31] || sz == 0) begin
            r.entry_done = 1'b1;
            prs_phase    = PH_TAG0;
          end else begin
            prs_bytes_left = sz;
            prs_phase      = PH_VALUE;
          end
        end else begin
          prs_cnt_idx = prs_cnt_idx + 2'd1;
        end
      end
      PH_VALUE: begin
        r.role = ROLE_VALUE;
        prs_bytes_left = prs_bytes_left - 4'd1;
        if (prs_bytes_left == 0) begin
          if (prs_type == CH_B_UP) begin
            prs_elems_left = prs_elems_left - 32'd1;
            if (prs_elems_left == 0) begin
              r.entry_done = 1'b1;
              prs_phase    = PH_TAG0;
            end else begin
              prs_bytes_left = elem_len(prs_sub);
              if (prs_bytes_left == 0) begin
                r.entry_done = 1'b1;
                prs_phase    = PH_TAG0;
              end
            end
          end else begin
            r.entry_done = 1'b1;
            prs_phase    = PH_TAG0;
          end
        end
      end
      PH_STRING: begin
        if (b == 8'h00) begin
          r.role       = ROLE_STR_END;
          r.entry_done = 1'b1;
          prs_phase    = PH_TAG0;
        end else begin
          r.role = ROLE_VALUE;
        end
      end
      default: ;
    endcase
    // block end mid-entry
    if (last && prs_phase != PH_TAG0) r.truncated = 1'b1;
    r.entry_tag = prs_tag;
    r.type_code = prs_type;
    r.sub_type  = prs_sub;
    if (last) reset_parser();
    return r;
  endfunction

  function automatic result_t lit_result(input logic [7:0] b, input role_t role,
                                         input logic [15:0] tag, input logic [7:0] t,
                                         input logic [7:0] st, input logic done,
                                         input logic unk, input logic trunc);
    result_t r;
    r.data_byte    = b;
    r.role         = role;
    r.entry_tag    = tag;
    r.type_code    = t;
    r.sub_type     = st;
    r.entry_done   = done;
    r.unknown_type = unk;
    r.truncated    = trunc;
    return r;
  endfunction

  function automatic void add_req(input logic [7:0] b, input logic last, input bit has_lit,
                                  input result_t lit);
    aux_req_t q;
    q.b       = b;
    q.last    = last;
    q.has_lit = has_lit;
    q.lit     = lit;
    aux_reqs.push_back(q);
  endfunction

  function automatic logic [7:0] pick_scalar(input int k);
    case (k)
      0:       return CH_A_UP;
      1:       return CH_C_LO;
      2:       return CH_C_UP;
      3:       return CH_S_LO;
      4:       return CH_S_UP;
      5:       return CH_I_LO;
      6:       return CH_I_UP;
      7:       return CH_F_LO;
      default: return CH_D_LO;
    endcase
  endfunction

  function automatic logic [7:0] pick_elem(input int k);
    case (k)
      0:       return CH_C_LO;
      1:       return CH_C_UP;
      2:       return CH_S_LO;
      3:       return CH_S_UP;
      4:       return CH_I_LO;
      5:       return CH_I_UP;
      default: return CH_F_LO;
    endcase
  endfunction

  // one entry with random content, possibly of an unknown type; returns 1 if it is left open
  function automatic bit gen_entry();
    logic [7:0]  t;
    logic [7:0]  st;
    logic [31:0] cnt;
    int          sel;
    int          n;
    int          esz;
    bit          open;
    open = 1'b0;
    add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    sel = $urandom_range(0, 15);
    if (sel <= 9) begin
      // scalar
      t = pick_scalar($urandom_range(0, 8));
      add_req(t, 1'b0, 1'b0, '0);
      n = scalar_len(t);
      repeat (n) add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    end else if (sel <= 11) begin
      // zero-terminated string
      t = (sel == 10) ? CH_Z_UP : CH_H_UP;
      add_req(t, 1'b0, 1'b0, '0);
      n = $urandom_range(0, 6);
      repeat (n) add_req(8'($urandom_range(1, 255)), 1'b0, 1'b0, '0);
      add_req(8'h00, 1'b0, 1'b0, '0);
    end else if (sel <= 14) begin
      // array
      add_req(CH_B_UP, 1'b0, 1'b0, '0);
      if ($urandom_range(0, 4) == 0) begin
        do st = 8'($urandom_range(0, 255)); while (elem_len(st) != 0);
      end else begin
        st = pick_elem($urandom_range(0, 6));
      end
      add_req(st, 1'b0, 1'b0, '0);
      sel = $urandom_range(0, 9);
      if (sel == 8) cnt = 32'h8000_0000 | $urandom;
      else if (sel == 9) cnt = 32'h0000_0100 | ($urandom & 32'h7fff_ffff);
      else cnt = $urandom_range(0, 4);
      for (int k = 0; k < 4; k++) add_req(cnt[8*k +: 8], 1'b0, 1'b0, '0);
      esz = elem_len(st);
      if (esz != 0 && !cnt[31] && cnt != 0) begin
        // huge counts never finish, so the block is cut short
        if (sel == 9) begin
          n = $urandom_range(0, 6);
          open = 1'b1;
        end else begin
          n = cnt * esz;
        end
        repeat (n) add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end
    end else begin
      // unknown type
      do t = 8'($urandom_range(0, 255));
      while (scalar_len(t) != 0 || t == CH_Z_UP || t == CH_H_UP || t == CH_B_UP);
      add_req(t, 1'b0, 1'b0, '0);
    end
    return open;
  endfunction

  // one auxiliary block: mostly whole entries, some cut short, some noise
  function automatic void gen_block();
    int mode;
    int start;
    int cut;
    int n;
    bit open;
    mode  = $urandom_range(0, 9);
    start = aux_reqs.size();
    open  = 1'b0;
    if (mode == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    end else begin
      n = $urandom_range(1, 4);
      for (int e = 0; e < n && !open; e++) open = gen_entry();
      if (mode == 1 && !open && aux_reqs.size() - start > 1) begin
        cut = $urandom_range(start, aux_reqs.size() - 2);
        while (aux_reqs.size() > cut + 1) void'(aux_reqs.pop_back());
      end
    end
    aux_reqs[aux_reqs.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] exp_v);
    if (err_cnt < MAX_PRINTED)
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got_v, exp_v);
    err_cnt++;
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.data_byte !== want.data_byte)
      report_mismatch("data_byte", got.data_byte, want.data_byte);
    if (got.role !== want.role) report_mismatch("role", got.role, want.role);
    if (got.entry_tag !== want.entry_tag)
      report_mismatch("entry_tag", got.entry_tag, want.entry_tag);
    if (got.type_code !== want.type_code)
      report_mismatch("type_code", got.type_code, want.type_code);
    if (got.sub_type !== want.sub_type)
      report_mismatch("sub_type", got.sub_type, want.sub_type);
    if (got.entry_done !== want.entry_done)
      report_mismatch("entry_done", got.entry_done, want.entry_done);
    if (got.unknown_type !== want.unknown_type)
      report_mismatch("unknown_type", got.unknown_type, want.unknown_type);
    if (got.truncated !== want.truncated)
      report_mismatch("truncated", got.truncated, want.truncated);
  endtask

  // accepted requests on both channels: predict on input, compare on output
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = parse_byte(in_ch.aux_byte, in_ch.block_last);
        if (acc_idx < aux_reqs.size() && aux_reqs[acc_idx].has_lit)
          want = aux_reqs[acc_idx].lit;
        pending_results.push_back(want);
        acc_idx++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.data_byte    = out_ch.data_byte;
        got.role         = role_t'(out_ch.role);
        got.entry_tag    = out_ch.entry_tag;
        got.type_code    = out_ch.type_code;
        got.sub_type     = out_ch.sub_type;
        got.entry_done   = out_ch.entry_done;
        got.unknown_type = out_ch.unknown_type;
        got.truncated    = out_ch.truncated;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected, byte", got.data_byte, 0);
        end else begin
          want = pending_results.pop_front();
          check_result(got, want);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random hold-offs, bursts, and one long stall
  initial begin : receiver
    int gap;
    int rx_cnt;
    out_ch.ready = 1'b0;
    rx_cnt = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_cnt == STALL_AT) begin
        out_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      gap = (((rx_cnt / 100) % 5) == 4) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      rx_cnt++;
    end
  end

  // sender and end of run
  initial begin : sender
    int gap;
    in_ch.valid      = 1'b0;
    in_ch.aux_byte   = 8'h00;
    in_ch.block_last = 1'b0;
    rst_n            = 1'b0;
    reset_parser();

    // directed table
    add_req(8'h58, 1'b0, 1'b1,
            lit_result(8'h58, ROLE_TAG, 16'h5800, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    add_req(8'h59, 1'b0, 1'b1,
            lit_result(8'h59, ROLE_TAG, 16'h5859, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    add_req(CH_A_UP, 1'b0, 1'b0, '0);
    add_req(8'hFF, 1'b0, 1'b0, '0);
    // all-zero tag and an unknown type of zero
    add_req(8'h00, 1'b0, 1'b1,
            lit_result(8'h00, ROLE_TAG, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    add_req(8'h00, 1'b0, 1'b1,
            lit_result(8'h00, ROLE_TAG, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    add_req(8'h00, 1'b0, 1'b1,
            lit_result(8'h00, ROLE_TYPE, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    // array with a zero count
    add_req(8'h6E, 1'b0, 1'b0, '0);
    add_req(8'h70, 1'b0, 1'b0, '0);
    add_req(CH_B_UP, 1'b0, 1'b0, '0);
    add_req(CH_C_LO, 1'b0, 1'b0, '0);
    repeat (3) add_req(8'h00, 1'b0, 1'b0, '0);
    add_req(8'h00, 1'b0, 1'b1,
            lit_result(8'h00, ROLE_COUNT, 16'h6E70, CH_B_UP, CH_C_LO, 1'b1, 1'b0, 1'b0));
    // array with a bad subtype and a positive count
    add_req(8'h62, 1'b0, 1'b0, '0);
    add_req(8'h73, 1'b0, 1'b0, '0);
    add_req(CH_B_UP, 1'b0, 1'b0, '0);
    add_req(8'h71, 1'b0, 1'b0, '0);
    add_req(8'h05, 1'b0, 1'b0, '0);
    repeat (2) add_req(8'h00, 1'b0, 1'b0, '0);
    add_req(8'h00, 1'b0, 1'b1,
            lit_result(8'h00, ROLE_COUNT, 16'h6273, CH_B_UP, 8'h71, 1'b1, 1'b0, 1'b0));
    // block ends after the tag
    add_req(8'h54, 1'b0, 1'b0, '0);
    add_req(8'h55, 1'b1, 1'b1,
            lit_result(8'h55, ROLE_TAG, 16'h5455, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
    dir_cnt = aux_reqs.size();

    // random blocks
    while (aux_reqs.size() < dir_cnt + RANDOM_ITEMS) gen_block();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < aux_reqs.size(); i++) begin
      // pause until every result is back
      if (i == dir_cnt || i == aux_reqs.size() / 2) begin
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
        @(posedge clk);
      end
      gap = (((i / 100) % 5) == 2) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid      <= 1'b1;
      in_ch.aux_byte   <= aux_reqs[i].b;
      in_ch.block_last <= aux_reqs[i].last;
      do @(posedge clk); while (!in_ch.ready);
    end
    in_ch.valid <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
